/* hdl/srsw_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_pkg
// shared types, codes and default sizes of the selective repeat sender window
// ---------------------------------------------------------------------------
package srsw_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int SEQ_BITS     = 16;
   localparam int PAYLOAD_BITS = 64;

   localparam int FIELD_SEQ_W     = 16;
   localparam int FIELD_PAYLOAD_W = 64;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_FULL    = 3'd1,
      STATUS_BADSUM  = 3'd2,
      STATUS_OUTSIDE = 3'd3,
      STATUS_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SLIDE
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic [FIELD_PAYLOAD_W-1:0] payload_word;
      logic [FIELD_SEQ_W-1:0]     ack_number;
      logic                       ack_checksum_ok;
      logic [FIELD_SEQ_W-1:0]     expired_seq;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       send_valid;
      logic [FIELD_SEQ_W-1:0]     send_seq;
      logic [FIELD_PAYLOAD_W-1:0] send_payload;
      logic                       timer_start;
      logic                       timer_stop;
      logic [FIELD_SEQ_W-1:0]     timer_seq;
      logic                       window_waiting;
   } rsp_type;

   // sequencer strobes
   typedef struct packed {
      logic busy;
      logic accept;
      logic exec;
      logic slide_step;
   } ctrl_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic slide_req;
      logic slide_more;
   } ctrl_stat_type;

endpackage

/* hdl/srsw_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/srsw_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_ctrl
// command sequencer: accept, execute, then after a base ack slide the window one slot a cycle
// ---------------------------------------------------------------------------
module srsw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  srsw_pkg::ctrl_stat_type stat,
   output srsw_pkg::ctrl_type     ctrl
);

   srsw_pkg::state_type state_ff;
   srsw_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = srsw_pkg::ST_EXEC;
            end
         end
         srsw_pkg::ST_EXEC: begin
            state_in = stat.slide_req ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_IDLE;
         end
         srsw_pkg::ST_SLIDE: begin
            if (!stat.slide_more) begin
               state_in = srsw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srsw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            ctrl.accept = start;
         end
         srsw_pkg::ST_EXEC: begin
            ctrl.busy = 1'b1;
            ctrl.exec = 1'b1;
         end
         srsw_pkg::ST_SLIDE: begin
            ctrl.busy       = 1'b1;
            ctrl.slide_step = stat.slide_more;
         end
         default: begin
            ctrl.busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srsw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/selective_repeat_sender_window.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_sender_window
// sender side window of a selective repeat arq link
// ---------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low.
// Every command gives exactly one response, shown on rsp_data for a single
// cycle with rsp_strobe high; the receiver cannot stall, so it must take the
// transfer in that cycle. In the accept cycle of a command the slot index is
// worked out and the payload memory read is launched; in the next cycle the
// window state is updated and the response is registered, and the response
// appears in the cycle after that, when, unless the window slides, the next
// command can already be accepted. An acknowledgement of the base sequence
// number holds busy while the window slides past each acknowledged slot at
// the base and then finds the scan done, since the acknowledge bits are
// scanned one slot per cycle. The payload store needs no clearing pass after
// reset.
// ---------------------------------------------------------------------------
module selective_repeat_sender_window #(
   parameter int WINDOW_SLOTS = srsw_pkg::WINDOW_SLOTS,
   parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS,
   parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srsw_pkg::req_type req_data,
   output logic              rsp_strobe,
   output srsw_pkg::rsp_type rsp_data
);

   localparam int IW    = $clog2(WINDOW_SLOTS);
   localparam int CW    = $clog2(WINDOW_SLOTS + 1);
   localparam int CMP_W = (SEQ_BITS > CW) ? SEQ_BITS : CW;
   localparam int SW    = srsw_pkg::FIELD_SEQ_W;
   localparam int PW    = srsw_pkg::FIELD_PAYLOAD_W;

   srsw_pkg::ctrl_type      ctrl;
   srsw_pkg::ctrl_stat_type stat;

   // window state
   logic [SEQ_BITS-1:0]     base_seq_ff, base_seq_in;
   logic [SEQ_BITS-1:0]     next_seq_ff, next_seq_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           base_ptr_ff, base_ptr_in;
   logic                    waiting_ff, waiting_in;
   logic [WINDOW_SLOTS-1:0] acked_ff, acked_in;

   // captured command
   srsw_pkg::cmd_type       cmd_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic                    sum_ok_ff;
   logic [SEQ_BITS-1:0]     seq_ff;
   logic                    hit_ff;
   logic                    at_base_ff;
   logic [IW-1:0]           idx_ff;

   // response register
   srsw_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    strobe_ff;

   // accept time offset and slot lookup
   logic [SEQ_BITS-1:0]     sel_seq;
   logic [SEQ_BITS-1:0]     off;
   logic [CMP_W-1:0]        off_cmp;
   logic                    in_win;
   logic [IW:0]             idx_sum;
   logic [IW-1:0]           idx;

   // payload memory
   logic                    mem_we;
   logic [IW-1:0]           wr_idx;
   logic [IW:0]             wr_sum;
   logic [PAYLOAD_BITS-1:0] rd_payload;

   logic                    full;
   logic                    slide_more;

   always_comb begin
      sel_seq = (req_data.cmd == srsw_pkg::CMD_ACK) ? SEQ_BITS'(req_data.ack_number)
                                                    : SEQ_BITS'(req_data.expired_seq);
      off     = sel_seq - base_seq_ff;
      off_cmp = CMP_W'(off);
      in_win  = off_cmp < CMP_W'(count_ff);
      // physical slot = base pointer + offset, wrapped once
      idx_sum = (IW + 1)'(base_ptr_ff) + (IW + 1)'(off_cmp[IW-1:0]);
      if (idx_sum >= (IW + 1)'(WINDOW_SLOTS)) begin
         idx = IW'(idx_sum - (IW + 1)'(WINDOW_SLOTS));
      end else begin
         idx = IW'(idx_sum);
      end
   end

   always_comb begin
      wr_sum = (IW + 1)'(base_ptr_ff) + (IW + 1)'(count_ff[IW-1:0]);
      if (wr_sum >= (IW + 1)'(WINDOW_SLOTS)) begin
         wr_idx = IW'(wr_sum - (IW + 1)'(WINDOW_SLOTS));
      end else begin
         wr_idx = IW'(wr_sum);
      end
   end

   assign full       = count_ff >= CW'(WINDOW_SLOTS);
   assign slide_more = (count_ff != '0) && acked_ff[base_ptr_ff];

   assign stat.slide_req  = (cmd_ff == srsw_pkg::CMD_ACK) && sum_ok_ff && hit_ff
                            && at_base_ff;
   assign stat.slide_more = slide_more;

   srsw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   srsw_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (WINDOW_SLOTS)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx),
      .wr_data (payload_ff),
      .rd_en   (ctrl.accept),
      .rd_addr (idx),
      .rd_data (rd_payload)
   );

   // execute and slide
   always_comb begin
      base_seq_in = base_seq_ff;
      next_seq_in = next_seq_ff;
      count_in    = count_ff;
      base_ptr_in = base_ptr_ff;
      waiting_in  = waiting_ff;
      acked_in    = acked_ff;
      mem_we      = 1'b0;
      rsp_in      = '0;

      if (ctrl.exec) begin
         case (cmd_ff)
            srsw_pkg::CMD_SEND: begin
               if (waiting_ff || full) begin
                  rsp_in.status = srsw_pkg::STATUS_FULL;
                  if (full) begin
                     waiting_in = 1'b1;
                  end
               end else begin
                  mem_we              = 1'b1;
                  acked_in[wr_idx]    = 1'b0;
                  count_in            = count_ff + CW'(1);
                  next_seq_in         = next_seq_ff + SEQ_BITS'(1);
                  waiting_in          = (count_ff + CW'(1)) >= CW'(WINDOW_SLOTS);
                  rsp_in.send_valid   = 1'b1;
                  rsp_in.send_seq     = SW'(next_seq_ff);
                  rsp_in.send_payload = PW'(payload_ff);
                  rsp_in.timer_start  = 1'b1;
                  rsp_in.timer_seq    = SW'(next_seq_ff);
               end
            end
            srsw_pkg::CMD_ACK: begin
               if (!sum_ok_ff) begin
                  rsp_in.status = srsw_pkg::STATUS_BADSUM;
               end else if (!hit_ff) begin
                  rsp_in.status = srsw_pkg::STATUS_OUTSIDE;
               end else begin
                  acked_in[idx_ff]  = 1'b1;
                  rsp_in.timer_stop = 1'b1;
                  rsp_in.timer_seq  = SW'(seq_ff);
                  if (at_base_ff) begin
                     waiting_in = 1'b0;
                  end
               end
            end
            srsw_pkg::CMD_TIMEOUT: begin
               if (!hit_ff) begin
                  rsp_in.status = srsw_pkg::STATUS_UNKNOWN;
               end else begin
                  rsp_in.send_valid   = 1'b1;
                  rsp_in.send_seq     = SW'(seq_ff);
                  rsp_in.send_payload = PW'(rd_payload);
                  rsp_in.timer_start  = 1'b1;
                  rsp_in.timer_stop   = 1'b1;
                  rsp_in.timer_seq    = SW'(seq_ff);
               end
            end
            default: begin
            end
         endcase
         rsp_in.window_waiting = waiting_in;
      end

      // retire one acknowledged slot at the base
      if (ctrl.slide_step) begin
         acked_in[base_ptr_ff] = 1'b0;
         count_in              = count_ff - CW'(1);
         base_seq_in           = base_seq_ff + SEQ_BITS'(1);
         if (base_ptr_ff == IW'(WINDOW_SLOTS - 1)) begin
            base_ptr_in = '0;
         end else begin
            base_ptr_in = base_ptr_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seq_ff <= SEQ_BITS'(1);
         next_seq_ff <= SEQ_BITS'(1);
         count_ff    <= '0;
         base_ptr_ff <= '0;
         waiting_ff  <= 1'b0;
         acked_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         base_seq_ff <= base_seq_in;
         next_seq_ff <= next_seq_in;
         count_ff    <= count_in;
         base_ptr_ff <= base_ptr_in;
         waiting_ff  <= waiting_in;
         acked_ff    <= acked_in;
         strobe_ff   <= ctrl.exec;
      end
   end

   // command capture and response payload
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff     <= req_data.cmd;
         payload_ff <= req_data.payload_word[PAYLOAD_BITS-1:0];
         sum_ok_ff  <= req_data.ack_checksum_ok;
         seq_ff     <= sel_seq;
         hit_ff     <= in_win;
         at_base_ff <= (off == '0);
         idx_ff     <= idx;
      end
      if (ctrl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = ctrl.busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // occupancy never exceeds the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW_SLOTS))
      else $error("window occupancy above slot count");

   // next sequence number tracks base plus occupancy
   a_seq_track: assert property (@(posedge clock) disable iff (reset)
      next_seq_ff == base_seq_ff + SEQ_BITS'(count_ff))
      else $error("next sequence out of step with window base");

   // a packet only goes out with an ok status
   a_send_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.send_valid |-> rsp_data.status == srsw_pkg::STATUS_OK)
      else $error("packet sent with error status");

   // sliding only happens after the base ack cleared waiting
   a_slide_nowait: assert property (@(posedge clock) disable iff (reset)
      ctrl.slide_step |-> !waiting_ff)
      else $error("window slide while waiting");

   // a response follows each executed command in the next cycle
   a_rsp_follow: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec |=> rsp_strobe)
      else $error("executed command gave no response");

endmodule
